>>> rtl/pcm_pkg.sv
// Package for the pointer candidate matcher: command and register codes,
// queue entry types and size constants. No dependencies.
`timescale 1ns / 1ps
package pcm_pkg;

  localparam int TARGETS_DEF = 16;
  localparam int MAX_OUT = 16;
  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SCAN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_OBJ_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEAREST_ONLY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESET_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_ADDRESSES = 3'd4;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_APPEND = 2'd1,
    OP_SCAN = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t op;
    logic [63:0] value;
    logic [63:0] location;
  } cmd_entry_t;

  typedef struct packed {
    logic [3:0] target_index;
    logic [31:0] child_id;
    logic [63:0] child_location;
    logic [63:0] pointer_value;
    logic [31:0] offset;
    logic last;
  } res_entry_t;

  typedef struct packed {
    logic [31:0] max_obj_size;
    logic nearest_only;
    logic preset_enable;
    logic [31:0] preset_offset;
  } cfg_t;

endpackage

>>> rtl/pointer_candidate_matcher_unit.sv
// Top level of the pointer candidate matcher: configuration registers, request
// and result queues. Depends on pcm_pkg, pcm_fifo, pcm_front and pcm_back.
//
//   Channel   Direction  Handshake          Payload
//   request   in         push / full        cmd, target_address, word_location, word_value
//   result    out        empty / pop        target_index, child_id, child_location,
//                                           pointer_value, offset, last
//   config    in         cfg_write          cfg_index, cfg_data
//
// A clear or append request takes effect in the back end as it leaves the queue.
// A scan walks the N targets, and nearest-only mode adds a first pass over them that
// finds the smallest offset.
// Reset clears the table count, the id counter, both queues and restores register defaults.
// A hit that waits on a full result queue stalls the walk; a busy back end fills the
// request queue.
`timescale 1ns / 1ps
module pointer_candidate_matcher_unit #(
  parameter int TARGETS = pcm_pkg::TARGETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     cmd,
  input  logic [63:0]                    target_address,
  input  logic [63:0]                    word_location,
  input  logic [63:0]                    word_value,
  output logic                           empty,
  input  logic                           pop,
  output logic [3:0]                     target_index,
  output logic [31:0]                    child_id,
  output logic [63:0]                    child_location,
  output logic [63:0]                    pointer_value,
  output logic [31:0]                    offset,
  output logic                           last,
  input  logic                           cfg_write,
  input  logic [pcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pcm_pkg::*;

  cfg_t cfg;
  logic wide_addresses;
  logic f_push;
  cmd_entry_t f_entry;
  logic [$bits(cmd_entry_t)-1:0] q_rdata;
  cmd_entry_t q_head;
  logic q_empty;
  logic q_pop;
  logic r_full;
  logic r_push;
  res_entry_t r_entry;
  logic [$bits(res_entry_t)-1:0] r_rdata;
  res_entry_t r_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_obj_size <= 32'd4096;
      cfg.nearest_only <= 1'b1;
      cfg.preset_enable <= 1'b0;
      cfg.preset_offset <= '0;
      wide_addresses <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_OBJ_SIZE: cfg.max_obj_size <= cfg_data;
        REG_NEAREST_ONLY: cfg.nearest_only <= cfg_data[0];
        REG_PRESET_ENABLE: cfg.preset_enable <= cfg_data[0];
        REG_PRESET_OFFSET: cfg.preset_offset <= cfg_data;
        REG_WIDE_ADDRESSES: wide_addresses <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  pcm_front u_front (
    .push(push),
    .cmd(cmd),
    .target_address(target_address),
    .word_location(word_location),
    .word_value(word_value),
    .wide_addresses(wide_addresses),
    .q_push(f_push),
    .q_entry(f_entry)
  );

  pcm_fifo #(
    .WIDTH($bits(cmd_entry_t)),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmd_q (
    .clk(clk),
    .rst(rst),
    .push(f_push),
    .wdata(f_entry),
    .full(full),
    .pop(q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign q_head = cmd_entry_t'(q_rdata);

  pcm_back #(
    .TARGETS(TARGETS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_empty(q_empty),
    .q_entry(q_head),
    .q_pop(q_pop),
    .r_full(r_full),
    .r_push(r_push),
    .r_entry(r_entry)
  );

  pcm_fifo #(
    .WIDTH($bits(res_entry_t)),
    .DEPTH(RESQ_DEPTH)
  ) u_res_q (
    .clk(clk),
    .rst(rst),
    .push(r_push),
    .wdata(r_entry),
    .full(r_full),
    .pop(pop),
    .rdata(r_rdata),
    .empty(empty)
  );

  assign r_head = res_entry_t'(r_rdata);
  assign target_index = r_head.target_index;
  assign child_id = r_head.child_id;
  assign child_location = r_head.child_location;
  assign pointer_value = r_head.pointer_value;
  assign offset = r_head.offset;
  assign last = r_head.last;

endmodule

>>> rtl/pcm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module pcm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/pcm_fifo.sv
// Small register-based FIFO used for the request queue and the result queue.
// No dependencies.
`timescale 1ns / 1ps
module pcm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/pcm_front.sv
// Front end: decodes incoming requests into queue entries and drops unused codes.
// Depends on pcm_pkg.
`timescale 1ns / 1ps
module pcm_front (
  input  logic                 push,
  input  logic [1:0]           cmd,
  input  logic [63:0]          target_address,
  input  logic [63:0]          word_location,
  input  logic [63:0]          word_value,
  input  logic                 wide_addresses,
  output logic                 q_push,
  output pcm_pkg::cmd_entry_t  q_entry
);
  import pcm_pkg::*;

  always_comb begin
    q_push = push;
    q_entry.op = OP_CLEAR;
    q_entry.value = target_address;
    q_entry.location = word_location;
    case (cmd)
      CMD_CLEAR: begin
        q_entry.op = OP_CLEAR;
      end
      CMD_APPEND: begin
        q_entry.op = OP_APPEND;
      end
      CMD_SCAN: begin
        q_entry.op = OP_SCAN;
        q_entry.value = wide_addresses ? word_value : {32'b0, word_value[31:0]};
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/pcm_back.sv
// Back end: owns the target table and walks it for each scan, emitting hits.
// Depends on pcm_pkg and pcm_ram.
`timescale 1ns / 1ps
module pcm_back #(
  parameter int TARGETS = pcm_pkg::TARGETS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pcm_pkg::cfg_t        cfg,
  input  logic                 q_empty,
  input  pcm_pkg::cmd_entry_t  q_entry,
  output logic                 q_pop,
  input  logic                 r_full,
  output logic                 r_push,
  output pcm_pkg::res_entry_t  r_entry
);
  import pcm_pkg::*;

  localparam int AW = (TARGETS > 1) ? $clog2(TARGETS) : 1;
  localparam int CW = $clog2(TARGETS + 1);
  localparam int NW = $clog2(MAX_OUT + 1);

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] issue, issue_next;
  logic dv, dv_next;
  logic [AW-1:0] didx, didx_next;
  logic [63:0] scan_ptr, scan_ptr_next;
  logic [63:0] scan_loc, scan_loc_next;
  logic [31:0] min_off, min_off_next;
  logic pv, pv_next;
  logic [AW-1:0] p_idx, p_idx_next;
  logic [31:0] p_off, p_off_next;
  logic [NW-1:0] nq, nq_next;
  logic [31:0] id_counter;

  logic ram_we;
  logic ram_re;
  logic [63:0] ram_rdata;
  logic [64:0] diff;
  logic [31:0] off;
  logic cand;
  logic qual;
  logic pass_end;
  logic step;
  logic r_last;

  pcm_ram #(
    .WIDTH(64),
    .DEPTH(TARGETS)
  ) u_table (
    .clk(clk),
    .we(ram_we),
    .waddr(count[AW-1:0]),
    .wdata(q_entry.value),
    .re(ram_re),
    .raddr(issue[AW-1:0]),
    .rdata(ram_rdata)
  );

  // A word hits at or below the entry within max_obj_size, at preset_offset if enabled.
  assign diff = {1'b0, ram_rdata} - {1'b0, scan_ptr};
  assign off = diff[31:0];
  assign cand = dv && !diff[64] && (diff[63:32] == '0) && (off <= cfg.max_obj_size)
              && (!cfg.preset_enable || (off == cfg.preset_offset));
  assign qual = cand && (!cfg.nearest_only || (off == min_off));
  assign pass_end = (issue == count) && !dv;

  always_comb begin
    state_next = state;
    count_next = count;
    issue_next = issue;
    dv_next = dv;
    didx_next = didx;
    scan_ptr_next = scan_ptr;
    scan_loc_next = scan_loc;
    min_off_next = min_off;
    pv_next = pv;
    p_idx_next = p_idx;
    p_off_next = p_off;
    nq_next = nq;
    q_pop = 1'b0;
    r_push = 1'b0;
    r_last = 1'b0;
    ram_we = 1'b0;
    step = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_entry.op)
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_APPEND: begin
              if (count < CW'(TARGETS)) begin
                ram_we = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_SCAN: begin
              scan_ptr_next = q_entry.value;
              scan_loc_next = q_entry.location;
              issue_next = '0;
              dv_next = 1'b0;
              min_off_next = cfg.max_obj_size;
              pv_next = 1'b0;
              nq_next = '0;
              state_next = cfg.nearest_only ? ST_MIN : ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MIN: begin
        if (pass_end) begin
          issue_next = '0;
          state_next = ST_EMIT;
        end else begin
          step = 1'b1;
          if (cand && (off < min_off)) begin
            min_off_next = off;
          end
        end
      end
      ST_EMIT: begin
        if (pv && (nq == NW'(MAX_OUT))) begin
          if (!r_full) begin
            r_push = 1'b1;
            r_last = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (pass_end) begin
          if (!pv) begin
            state_next = ST_IDLE;
          end else if (!r_full) begin
            r_push = 1'b1;
            r_last = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (!(qual && pv && r_full)) begin
          step = 1'b1;
          if (qual) begin
            r_push = pv;
            pv_next = 1'b1;
            p_idx_next = didx;
            p_off_next = off;
            nq_next = nq + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    ram_re = step && (issue < count);
    if (step) begin
      dv_next = ram_re;
      didx_next = issue[AW-1:0];
      if (ram_re) begin
        issue_next = issue + 1'b1;
      end
    end
  end

  always_comb begin
    r_entry.target_index = 4'(p_idx);
    r_entry.child_id = id_counter;
    r_entry.child_location = scan_loc;
    r_entry.pointer_value = scan_ptr;
    r_entry.offset = p_off;
    r_entry.last = r_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      issue <= '0;
      dv <= 1'b0;
      pv <= 1'b0;
      nq <= '0;
      id_counter <= '0;
    end else begin
      count <= count_next;
      issue <= issue_next;
      dv <= dv_next;
      pv <= pv_next;
      nq <= nq_next;
      if (r_push) begin
        id_counter <= id_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    didx <= didx_next;
    scan_ptr <= scan_ptr_next;
    scan_loc <= scan_loc_next;
    min_off <= min_off_next;
    p_idx <= p_idx_next;
    p_off <= p_off_next;
  end

endmodule
